### src/cross_channel_lrn_unit_defines.svh
// Assertion macros for the cross-channel response normalization unit.
`ifndef CROSS_CHANNEL_LRN_UNIT_DEFINES_SVH
`define CROSS_CHANNEL_LRN_UNIT_DEFINES_SVH

// condition holds on every clock out of reset
`define CCL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the next clock
`define CCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ccl_pkg.sv
// Types, constants and constant tables of the cross-channel normalization unit.
package ccl_pkg;

  localparam int MAX_WINDOW_DEF   = 16;
  localparam int CHANNEL_BITS_DEF = 12;
  localparam int MAX_OUT          = 8;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 24;
  localparam int DIV_STEPS        = 26;
  localparam int ROOT_STEPS       = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BETA   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIAS   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd3;

  localparam logic [23:0] ALPHA_RESET  = 24'd1678;
  localparam logic [15:0] BETA_RESET   = 16'd12288;
  localparam logic [23:0] BIAS_RESET   = 24'd65536;
  localparam logic [3:0]  WINDOW_RESET = 4'd5;

  localparam logic [29:0] SQ_CAP = 30'h3FFF_FFFF;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [11:0]        out_channel;
    logic               saturated;
    logic               last_result;
  } out_item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bv;
    logic [63:0] val;
    r   = '0;
    bv  = 64'd1 << 62;
    val = v;
    for (int n = 0; n < 32; n++) begin
      if (val >= r + bv) begin
        val = val - (r + bv);
        r   = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // successive square roots of two in Q.30, one 32-bit entry per step
  function automatic logic [ROOT_STEPS*32-1:0] root_table();
    logic [ROOT_STEPS*32-1:0] t;
    logic [63:0] root;
    t    = '0;
    root = 64'd1 << 31;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      root = isqrt64(root << 30);
      t[k*32 +: 32] = root[31:0];
    end
    return t;
  endfunction

  localparam logic [ROOT_STEPS*32-1:0] ROOT_TABLE = root_table();

endpackage

### src/cross_channel_lrn_unit.sv
// Cross-channel local response normalization with one shared multiplier.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | in_data (sample, last_channel)
//   out     | out_valid/out_stall| out_data (value, channel, saturated, last)
//   cfg     | cfg_write          | cfg_index, cfg_data
//
// Each result runs the sum, multiply, divide, base, normalize, log, exponent,
// exp and finishing steps on the one multiplier and divider; a zero base skips
// from the base step to the finish. An item passes through setup, then runs
// those steps for each result it releases.
// in_stall is high until the last result of an item is in the output register.
// Synchronous reset clears the rings and counters and loads the configuration registers with their reset values.
// A stalled output holds the sequencer at its last step.
module cross_channel_lrn_unit
  import ccl_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "cross_channel_lrn_unit_defines.svh"

  localparam int RW = $clog2(MAX_WINDOW);
  localparam int CB = CHANNEL_BITS;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SETUP = 13'b0000000000010,
    ST_SUM   = 13'b0000000000100,
    ST_MULLO = 13'b0000000001000,
    ST_MULHI = 13'b0000000010000,
    ST_DIV   = 13'b0000000100000,
    ST_BASE  = 13'b0000001000000,
    ST_NORM  = 13'b0000010000000,
    ST_LOG   = 13'b0000100000000,
    ST_EMUL  = 13'b0001000000000,
    ST_EXP   = 13'b0010000000000,
    ST_PROD  = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [23:0] alpha_gain;
  logic [15:0] beta_exponent;
  logic [23:0] bias_offset;
  logic [3:0]  window_size;

  logic signed [15:0] value_ring [MAX_WINDOW];
  logic [29:0]        square_ring [MAX_WINDOW];

  logic [CB-1:0] in_count;
  logic [CB-1:0] out_count;
  logic [RW-1:0] slot;
  logic          last_flag;
  logic [CB:0]   pending;
  logic [3:0]    n_res;
  logic [3:0]    r_idx;
  logic signed [4:0] d_off;
  logic [33:0]   square_sum;
  logic [57:0]   scaled_prod;
  logic [25:0]   div_q;
  logic [4:0]    div_rem;
  logic [4:0]    step;
  logic [30:0]   mant;
  logic [4:0]    expo;
  logic [15:0]   frac;
  logic signed [8:0] ip;
  logic [15:0]   fb;
  logic [31:0]   acc;
  logic [16:0]   ax;
  logic          neg;
  logic          zero_base;
  logic [47:0]   prod;

  logic [3:0]  ws;
  logic [2:0]  h;
  assign ws = (window_size == 4'd0) ? 4'd1 : window_size;
  assign h  = ws[3:1];

  // exponent operand: -log2(base)
  logic signed [21:0] lval, nl;
  logic [20:0]        emag;
  logic               esign;
  assign lval  = {6'(expo) - 6'sd16, frac};
  assign nl    = -lval;
  assign esign = nl[21];
  assign emag  = esign ? 21'(-nl) : nl[20:0];

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MULLO: begin mul_a = {8'd0, alpha_gain}; mul_b = {15'd0, square_sum[16:0]}; end
      ST_MULHI: begin mul_a = {8'd0, alpha_gain}; mul_b = {15'd0, square_sum[33:17]}; end
      ST_LOG:   begin mul_a = {1'b0, mant}; mul_b = {1'b0, mant}; end
      ST_EMUL:  begin mul_a = {16'd0, beta_exponent}; mul_b = {11'd0, emag}; end
      ST_EXP:   begin mul_a = acc; mul_b = ROOT_TABLE[step[3:0]*32 +: 32]; end
      ST_PROD:  begin mul_a = {15'd0, ax}; mul_b = acc; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [38:0] eval_e;
  assign eval_e = esign ? -$signed({2'b0, mul_p[36:0]}) : $signed({2'b0, mul_p[36:0]});

  // ring addressing
  logic [CB:0]          a_cur;
  logic signed [CB+1:0] ka;
  logic signed [CB+1:0] off;
  logic [RW-1:0]        off_n;
  logic [RW:0]          ring_idx_w;
  logic [RW-1:0]        ring_idx;
  logic [CB-1:0]        j_cur;
  logic                 in_win;
  assign a_cur = pending - (CB+1)'(1) - (CB+1)'(r_idx);
  assign ka    = $signed({1'b0, a_cur}) - (CB+2)'(d_off);
  assign off   = (state == ST_SUM) ? ka : $signed({1'b0, a_cur});
  assign off_n = off[RW-1:0];
  assign ring_idx_w = (slot >= off_n) ? (RW+1)'(slot) - (RW+1)'(off_n)
                                      : (RW+1)'(slot) + (RW+1)'(MAX_WINDOW) - (RW+1)'(off_n);
  assign ring_idx = ring_idx_w[RW-1:0];
  assign j_cur = out_count + CB'(r_idx);
  assign in_win = (ka >= 0) && (ka <= (CB+2)'(MAX_WINDOW - 1)) &&
                  !((d_off < 0) && ({1'b0, j_cur} < (CB+1)'(-d_off)));

  // input square
  logic signed [31:0] sq_full;
  logic [29:0]        sq_cap;
  assign sq_full = in_data.sample * in_data.sample;
  assign sq_cap  = (sq_full > 32'sd1073741823) ? SQ_CAP : sq_full[29:0];

  // result count
  logic [CB:0] pend_new;
  logic [CB:0] n_raw;
  logic [3:0]  n_new;
  assign pend_new = (CB+1)'((in_count - out_count) & {CB{1'b1}}) + (CB+1)'(1);
  assign n_raw = last_flag ? pend_new :
                 ((pend_new > (CB+1)'(h)) ? pend_new - (CB+1)'(h) : '0);
  assign n_new = (n_raw > (CB+1)'(MAX_OUT)) ? 4'(MAX_OUT) : n_raw[3:0];

  // divide step
  logic [4:0] div_t;
  logic       div_bit;
  assign div_t   = {div_rem[3:0], div_q[25]};
  assign div_bit = div_t >= {1'b0, ws};

  // log step
  logic [31:0] log_t;
  assign log_t = mul_p[61:30];

  // final shift and saturation
  logic signed [9:0] sh;
  logic [63:0]       mag;
  logic [15:0]       limit;
  logic              over;
  logic [15:0]       mag16;
  logic [15:0]       y;
  always_comb begin
    sh    = 10'sd30 - 10'(ip);
    limit = neg ? 16'd32768 : 16'd32767;
    mag   = '0;
    if (prod == '0) begin
      mag = '0;
    end else if (sh <= 0) begin
      if (sh <= -10'sd17) mag = 64'(limit) + 64'd1;
      else mag = {16'd0, prod} << 5'(-sh);
    end else if (sh >= 10'sd63) begin
      mag = '0;
    end else begin
      mag = ({16'd0, prod} + (64'd1 << 6'(sh - 10'sd1))) >> 6'(sh);
    end
    over  = mag > 64'(limit);
    mag16 = over ? limit : mag[15:0];
    y     = neg ? 16'(-mag16) : mag16;
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain    <= ALPHA_RESET;
      beta_exponent <= BETA_RESET;
      bias_offset   <= BIAS_RESET;
      window_size   <= WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALPHA:  alpha_gain    <= cfg_data[23:0];
        REG_BETA:   beta_exponent <= cfg_data[15:0];
        REG_BIAS:   bias_offset   <= cfg_data[23:0];
        REG_WINDOW: window_size   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        value_ring[k]  <= '0;
        square_ring[k] <= '0;
      end
    end else if (in_valid && !in_stall) begin
      value_ring[slot]  <= in_data.sample;
      square_ring[slot] <= sq_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_count   <= '0;
      out_count  <= '0;
      slot       <= '0;
      last_flag  <= 1'b0;
      square_sum <= '0;
      out_valid  <= 1'b0;
      r_idx      <= '0;
      n_res      <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_FIN) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_flag <= in_data.last_channel;
            state     <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          pending <= pend_new;
          n_res   <= n_new;
          r_idx   <= '0;
          d_off   <= -$signed({2'b0, h});
          square_sum <= '0;
          if (n_new == 4'd0) begin
            in_count <= in_count + CB'(1);
            slot     <= (slot == RW'(MAX_WINDOW - 1) || in_count == {CB{1'b1}})
                        ? '0 : slot + RW'(1);
            state    <= ST_IDLE;
          end else begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (in_win) square_sum <= square_sum + 34'(square_ring[ring_idx]);
          if (d_off == $signed({2'b0, h})) state <= ST_MULLO;
          else d_off <= d_off + 5'sd1;
        end
        ST_MULLO: begin
          scaled_prod <= mul_p[57:0];
          if (a_cur <= (CB+1)'(MAX_WINDOW - 1)) begin
            neg <= value_ring[ring_idx][15];
            ax  <= value_ring[ring_idx][15] ? -17'(value_ring[ring_idx])
                                            : 17'(value_ring[ring_idx]);
          end else begin
            neg <= 1'b0;
            ax  <= '0;
          end
          state <= ST_MULHI;
        end
        ST_MULHI: begin
          div_q   <= 26'((scaled_prod + {mul_p[40:0], 17'd0}) >> 32);
          div_rem <= '0;
          step    <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= div_bit ? div_t - {1'b0, ws} : div_t;
          div_q   <= {div_q[24:0], div_bit};
          step    <= step + 5'd1;
          if (step == 5'(DIV_STEPS - 1)) state <= ST_BASE;
        end
        ST_BASE: begin
          mant      <= 31'(27'(bias_offset) + 27'(div_q));
          zero_base <= (27'(bias_offset) + 27'(div_q)) == '0;
          expo      <= 5'd30;
          step      <= '0;
          frac      <= '0;
          if ((27'(bias_offset) + 27'(div_q)) == '0) state <= ST_FIN;
          else state <= ST_NORM;
        end
        ST_NORM: begin
          if (mant[30]) state <= ST_LOG;
          else begin
            mant <= {mant[29:0], 1'b0};
            expo <= expo - 5'd1;
          end
        end
        ST_LOG: begin
          frac <= {frac[14:0], log_t[31]};
          mant <= log_t[31] ? log_t[31:1] : log_t[30:0];
          step <= step + 5'd1;
          if (step == 5'd15) state <= ST_EMUL;
        end
        ST_EMUL: begin
          ip    <= eval_e[38:30];
          fb    <= eval_e[29:14];
          acc   <= 32'd1 << 30;
          step  <= '0;
          state <= ST_EXP;
        end
        ST_EXP: begin
          if (fb[4'd15 - step[3:0]]) acc <= 32'((mul_p + 64'd536870912) >> 30);
          step <= step + 5'd1;
          if (step == 5'(ROOT_STEPS - 1)) state <= ST_PROD;
        end
        ST_PROD: begin
          prod      <= mul_p[47:0];
          zero_base <= 1'b0;
          state     <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.out_value    <= zero_base ? 16'sd0 : $signed(y);
            out_data.saturated    <= zero_base | over;
            out_data.out_channel  <= 12'(j_cur);
            out_data.last_result  <= last_flag && (r_idx == n_res - 4'd1);
            if (r_idx == n_res - 4'd1) begin
              state <= ST_IDLE;
              if (last_flag) begin
                in_count  <= '0;
                out_count <= '0;
                slot      <= '0;
              end else begin
                in_count  <= in_count + CB'(1);
                out_count <= out_count + CB'(n_res);
                slot      <= (slot == RW'(MAX_WINDOW - 1) || in_count == {CB{1'b1}})
                             ? '0 : slot + RW'(1);
              end
            end else begin
              r_idx      <= r_idx + 4'd1;
              d_off      <= -$signed({2'b0, h});
              square_sum <= '0;
              state      <= ST_SUM;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CCL_ASSERT_NEXT(a_accept_setup, in_valid && !in_stall, state == ST_SETUP, "accept did not start setup")
  `CCL_ASSERT(a_result_bound, (state == ST_IDLE) || (state == ST_SETUP) || (r_idx < n_res), "result index beyond count")
  `CCL_ASSERT(a_div_bound, (state != ST_DIV) || (step < 5'(DIV_STEPS)), "divide ran too long")

endmodule

### dv/cross_channel_lrn_unit_tb.sv
// Self-checking testbench for the cross-channel response normalization unit.
module cross_channel_lrn_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccl_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  class lrn_scoreboard;
    logic [23:0] alpha;
    logic [15:0] beta;
    logic [23:0] bias;
    logic [3:0]  win;
    logic [15:0] values [16];
    logic [29:0] squares [16];
    logic [33:0] window_sum;
    logic [11:0] in_ch;
    logic [11:0] out_ch;
    logic [31:0] roots [16];
    out_item_t   expected_q [$];
    int          errors;
    int          inputs_seen;
    int          results_seen;

    function new();
      longint unsigned root;
      alpha = ALPHA_RESET;
      beta  = BETA_RESET;
      bias  = BIAS_RESET;
      win   = WINDOW_RESET;
      foreach (values[k]) begin
        values[k]  = '0;
        squares[k] = '0;
      end
      window_sum = '0;
      in_ch      = '0;
      out_ch     = '0;
      errors     = 0;
      inputs_seen  = 0;
      results_seen = 0;
      root = 64'd1 << 31;
      for (int k = 0; k < 16; k++) begin
        root     = int_sqrt(root << 30);
        roots[k] = root[31:0];
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_ALPHA:  alpha = val[23:0];
        REG_BETA:   beta  = val[15:0];
        REG_BIAS:   bias  = val[23:0];
        REG_WINDOW: win   = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] normalized(int x, longint unsigned s, output logic sat);
      longint unsigned ws, base, t, m, frac, f, g, ax, prod, mag, lim, ue, q, acc;
      longint l, ev, ip, sh;
      int e;
      ws  = (win == 0) ? 1 : win;
      sat = 1'b0;
      base = longint'(bias) + (((longint'(alpha) * s) / ws) >> 32);
      if (base == 0) begin
        sat = 1'b1;
        return 16'd0;
      end
      e = 0;
      t = base;
      while (t > 1) begin
        t = t >> 1;
        e++;
      end
      m = (e <= 30) ? (base << (30 - e)) : (base >> (e - 30));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      l  = longint'(e - 16) * 65536 + longint'(frac);
      ev = longint'(beta) * (-l);
      if (ev >= 0) begin
        ip = ev >>> 30;
        f  = ev & ((64'd1 << 30) - 1);
      end else begin
        ue = -ev;
        q  = (ue + (64'd1 << 30) - 1) >> 30;
        ip = -longint'(q);
        f  = (q << 30) - ue;
      end
      f   = f >> 14;
      acc = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
        if (f[15-k]) acc = (acc * roots[k] + (64'd1 << 29)) >> 30;
      g    = acc;
      ax   = (x < 0) ? -x : x;
      prod = ax * g;
      lim  = (x < 0) ? 32768 : 32767;
      sh   = 30 - ip;
      if (prod == 0) mag = 0;
      else if (sh <= 0) mag = (-sh >= 17) ? lim + 1 : (prod << (-sh));
      else if (sh >= 63) mag = 0;
      else mag = (prod + (64'd1 << (sh - 1))) >> sh;
      if (mag > lim) begin
        mag = lim;
        sat = 1'b1;
      end
      return (x < 0) ? 16'(-longint'(mag)) : 16'(mag);
    endfunction

    function void note(in_item_t it);
      int x, h, pending, n, a, ka, v, j;
      int unsigned slot, ws;
      longint unsigned sq, s;
      logic sat;
      out_item_t res;
      inputs_seen++;
      x  = it.sample;
      slot = in_ch % 16;
      ws = (win == 0) ? 1 : win;
      h  = ws / 2;
      sq = longint'(x) * longint'(x);
      if (sq > SQ_CAP) sq = SQ_CAP;
      values[slot]  = it.sample;
      squares[slot] = sq[29:0];
      pending = int'(12'(in_ch - out_ch)) + 1;
      if (it.last_channel) n = pending;
      else n = (pending > h) ? pending - h : 0;
      if (n > MAX_OUT) n = MAX_OUT;
      for (int r = 0; r < n; r++) begin
        j = int'(12'(out_ch + r));
        a = pending - 1 - r;
        s = 0;
        v = 0;
        for (int d = -h; d <= h; d++) begin
          ka = a - d;
          if (ka < 0 || ka > 15 || j + d < 0) continue;
          s += squares[(slot + 16 - ka) % 16];
        end
        if (a <= 15) v = $signed(values[(slot + 16 - a) % 16]);
        window_sum      = s[33:0];
        res.out_value   = normalized(v, window_sum, sat);
        res.out_channel = j[11:0];
        res.saturated   = sat;
        res.last_result = it.last_channel && (r == n - 1);
        expected_q.push_back(res);
      end
      if (it.last_channel) begin
        in_ch  = '0;
        out_ch = '0;
      end else begin
        in_ch  = in_ch + 12'd1;
        out_ch = out_ch + 12'(n);
      end
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_value !== want.out_value || got.out_channel !== want.out_channel ||
          got.saturated !== want.saturated || got.last_result !== want.last_result) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  in_item_t in_data;
  logic out_valid, out_stall;
  out_item_t out_data;
  logic cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  lrn_scoreboard sb = new();
  int stall_mode;
  int stall_count;
  int burst_left;
  bit gaps_on;
  int idle_cycles;
  int phase_count;

  cross_channel_lrn_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note(in_data);
      if (out_valid && !out_stall) sb.check(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    stall_count = stall_count + 1;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 99) < 35);
      2: out_stall = ((stall_count % 23) < 9);
      default: out_stall = ($urandom_range(0, 99) < 80);
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_all(input logic [23:0] a, input logic [15:0] b, input logic [23:0] c,
                         input logic [3:0] w);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, 24'(b));
    write_reg(REG_BIAS, c);
    write_reg(REG_WINDOW, 24'(w));
    phase_count++;
  endtask

  task automatic send(input logic [15:0] smp, input logic lst);
    if (burst_left <= 0) begin
      if (gaps_on) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_data.sample = smp;
    in_data.last_channel = lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 16'h8000;
    if (sel < 14) return 16'h7FFF;
    if (sel < 18) return 16'h0000;
    if (sel < 35) return 16'($signed($urandom_range(0, 8191)) - 4096);
    return 16'($urandom);
  endfunction

  task automatic random_positions(input int count);
    int len;
    while (count > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int c = 0; c < len && count > 0; c++) begin
        count--;
        // a phase may end mid position
        send(pick_sample(), (c == len - 1) || ($urandom_range(0, 39) == 0));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data = '0;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_count = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    phase_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: single channel, extremes, short positions
    send(16'h8000, 1'b1);
    send(16'h7FFF, 1'b1);
    send(16'h0000, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h7FFF, 1'b0);
    send(16'h1000, 1'b0);
    send(16'hF000, 1'b0);
    send(16'h0001, 1'b1);
    drain();
    // zero base and overflow
    set_all(24'd0, 16'd0, 24'd0, 4'd1);
    send(16'h1234, 1'b0);
    send(16'h8000, 1'b1);
    drain();
    set_all(24'hFFFFFF, 16'hFFFF, 24'd1, 4'd15);
    for (int c = 0; c < 9; c++) send((c % 2) ? 16'h8000 : 16'h7FFF, c == 8);
    drain();
    set_all(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 4'd2);
    send(16'h7FFF, 1'b0);
    send(16'h0000, 1'b0);
    send(16'h8000, 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      stall_mode = p % 4;
      gaps_on = (p % 3 != 0);
      case (p)
        0: set_all(ALPHA_RESET, BETA_RESET, BIAS_RESET, WINDOW_RESET);
        1: set_all(24'hFFFFFF, 16'h0000, 24'hFFFFFF, 4'd1);
        2: set_all(24'd0, 16'hFFFF, 24'd0, 4'd15);
        3: set_all(24'hFFFFFF, 16'hFFFF, 24'd1, 4'd7);
        default: set_all(24'($urandom), 16'($urandom), 24'($urandom_range(0, 1) ? $urandom :
                         $urandom_range(0, 255)), 4'($urandom_range(1, 15)));
      endcase
      random_positions(50);
      drain();
    end

    $display("covered %0d transfers in, %0d results out, %0d register settings",
             sb.inputs_seen, sb.results_seen, phase_count + 1);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/ccl_pkg.sv
src/cross_channel_lrn_unit.sv
dv/cross_channel_lrn_unit_tb.sv
